@@ hdl/rv32ie_pkg.sv @@
package rv32ie_pkg;

  localparam int NUM_REGS_DEF = 32;

  localparam logic ITEM_EXEC     = 1'b0;
  localparam logic ITEM_LOAD_RET = 1'b1;

  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_OP_IMM = 7'h13;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic [31:0] instr_word;
    logic [31:0] load_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        mem_request;
    logic        mem_write;
    logic [31:0] mem_addr;
    logic [1:0]  mem_size;
    logic [31:0] store_data;
    logic        halted;
    logic        waiting_load;
  } out_item_t;

  typedef struct packed {
    logic [31:0] pc;
    logic        halt;
    logic        load_pending;
    logic [4:0]  load_dest;
    logic [1:0]  load_size;
    logic        load_unsigned;
  } core_state_t;

  typedef struct packed {
    logic        en;
    logic [4:0]  idx;
    logic [31:0] data;
  } rf_write_t;

endpackage

@@ hdl/rv32ie_regfile.sv @@
module rv32ie_regfile #(
  parameter int NUM_REGS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 ren,
  input  logic [4:0]           raddr1,
  input  logic [4:0]           raddr2,
  input  rv32ie_pkg::rf_write_t wr,
  output logic [31:0]          rdata1,
  output logic [31:0]          rdata2
);
  import rv32ie_pkg::*;

  localparam int AW = $clog2(NUM_REGS);

  logic [31:0]         mem [NUM_REGS];
  logic [NUM_REGS-1:0] valid;

  logic [31:0] mem1;
  logic [31:0] mem2;
  logic [31:0] fwd_data;
  logic        fwd1;
  logic        fwd2;
  logic        zero1;
  logic        zero2;
  logic        wr_ok;
  logic        rd1_ok;
  logic        rd2_ok;

  // x0 and indexes past the file read as zero and drop writes
  assign wr_ok  = wr.en && (wr.idx != 5'd0) && ({1'b0, wr.idx} < 6'(NUM_REGS));
  assign rd1_ok = (raddr1 != 5'd0) && ({1'b0, raddr1} < 6'(NUM_REGS))
                  && valid[raddr1[AW-1:0]];
  assign rd2_ok = (raddr2 != 5'd0) && ({1'b0, raddr2} < 6'(NUM_REGS))
                  && valid[raddr2[AW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_ok) begin
      valid[wr.idx[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr.idx[AW-1:0]] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (ren) begin
      mem1     <= mem[raddr1[AW-1:0]];
      mem2     <= mem[raddr2[AW-1:0]];
      fwd_data <= wr.data;
      fwd1     <= wr_ok && (wr.idx == raddr1);
      fwd2     <= wr_ok && (wr.idx == raddr2);
      zero1    <= !rd1_ok;
      zero2    <= !rd2_ok;
    end
  end

  assign rdata1 = fwd1 ? fwd_data : (zero1 ? 32'd0 : mem1);
  assign rdata2 = fwd2 ? fwd_data : (zero2 ? 32'd0 : mem2);

endmodule

@@ hdl/rv32ie_execute.sv @@
module rv32ie_execute (
  input  rv32ie_pkg::in_item_t    item,
  input  rv32ie_pkg::core_state_t st,
  input  logic [31:0]             rs1_val,
  input  logic [31:0]             rs2_val,
  output rv32ie_pkg::core_state_t st_next,
  output rv32ie_pkg::rf_write_t   wb,
  output rv32ie_pkg::out_item_t   res
);
  import rv32ie_pkg::*;

  function automatic logic [31:0] alu(input logic [2:0] f3, input logic alt,
                                      input logic [31:0] a, input logic [31:0] b);
    logic [31:0] r;
    unique case (f3)
      3'd0:    r = alt ? a - b : a + b;
      3'd1:    r = a << b[4:0];
      3'd2:    r = {31'd0, $signed(a) < $signed(b)};
      3'd3:    r = {31'd0, a < b};
      3'd4:    r = a ^ b;
      3'd5:    r = alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
      3'd6:    r = a | b;
      default: r = a & b;
    endcase
    return r;
  endfunction

  function automatic logic taken(input logic [2:0] f3, input logic [31:0] a,
                                 input logic [31:0] b);
    logic t;
    unique case (f3)
      3'd0:    t = (a == b);
      3'd1:    t = (a != b);
      3'd4:    t = $signed(a) < $signed(b);
      3'd5:    t = !($signed(a) < $signed(b));
      3'd6:    t = a < b;
      3'd7:    t = a >= b;
      default: t = 1'b0;
    endcase
    return t;
  endfunction

  logic [31:0] w;
  logic [6:0]  opc;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic        alt;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_j;
  logic [31:0] imm_u;
  logic [31:0] pc4;
  logic [31:0] ld_ext;

  assign w     = item.instr_word;
  assign opc   = w[6:0];
  assign rd    = w[11:7];
  assign f3    = w[14:12];
  assign alt   = w[30];
  assign imm_i = {{20{w[31]}}, w[31:20]};
  assign imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
  assign imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  assign imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
  assign imm_u = {w[31:12], 12'd0};
  assign pc4   = st.pc + 32'd4;

  always_comb begin
    unique case (st.load_size)
      SIZE_BYTE: ld_ext = st.load_unsigned ? {24'd0, item.load_data[7:0]}
                                           : {{24{item.load_data[7]}}, item.load_data[7:0]};
      SIZE_HALF: ld_ext = st.load_unsigned ? {16'd0, item.load_data[15:0]}
                                           : {{16{item.load_data[15]}}, item.load_data[15:0]};
      default:   ld_ext = item.load_data;
    endcase
  end

  always_comb begin
    st_next = st;
    wb      = '0;
    res     = '0;
    if (item.opcode == ITEM_LOAD_RET) begin
      if (st.load_pending) begin
        wb.en   = 1'b1;
        wb.idx  = st.load_dest;
        wb.data = ld_ext;
        st_next.load_pending = 1'b0;
      end
    end else if (!st.load_pending) begin
      st_next.pc = pc4;
      unique case (opc)
        OPC_LUI: begin
          wb = '{en: 1'b1, idx: rd, data: imm_u};
        end
        OPC_AUIPC: begin
          wb = '{en: 1'b1, idx: rd, data: st.pc + imm_u};
        end
        OPC_JAL: begin
          wb = '{en: 1'b1, idx: rd, data: pc4};
          st_next.pc = st.pc + imm_j;
        end
        OPC_JALR: begin
          wb = '{en: 1'b1, idx: rd, data: pc4};
          st_next.pc = (rs1_val + imm_i) & ~32'd1;
        end
        OPC_BRANCH: begin
          if (taken(f3, rs1_val, rs2_val)) begin
            st_next.pc = st.pc + imm_b;
          end
        end
        OPC_LOAD: begin
          if (f3 == 3'd0 || f3 == 3'd1 || f3 == 3'd2 || f3 == 3'd4 || f3 == 3'd5) begin
            res.mem_request       = 1'b1;
            res.mem_addr          = rs1_val + imm_i;
            res.mem_size          = f3[1:0];
            st_next.load_pending  = 1'b1;
            st_next.load_dest     = rd;
            st_next.load_size     = f3[1:0];
            st_next.load_unsigned = f3[2];
          end
        end
        OPC_STORE: begin
          if (f3 <= 3'd2) begin
            res.mem_request = 1'b1;
            res.mem_write   = 1'b1;
            res.mem_addr    = rs1_val + imm_s;
            res.mem_size    = f3[1:0];
            res.store_data  = rs2_val;
          end
        end
        OPC_OP_IMM: begin
          wb = '{en: 1'b1, idx: rd, data: alu(f3, (f3 == 3'd5) && alt, rs1_val, imm_i)};
        end
        OPC_OP: begin
          wb = '{en: 1'b1, idx: rd, data: alu(f3, alt, rs1_val, rs2_val)};
        end
        OPC_SYSTEM: begin
          st_next.halt = 1'b1;
        end
        default: begin
        end
      endcase
    end
    res.next_pc      = st_next.pc;
    res.halted       = st_next.halt;
    res.waiting_load = st_next.load_pending;
  end

endmodule

@@ hdl/rv32i_instruction_execute_core.sv @@
// Channel  Direction  Handshake              Beat
// in       input      in_valid / in_stall    in_item_t: opcode, instr_word, load_data
// out      output     out_valid / out_stall  out_item_t: next_pc, memory request, status
// cfg      input      cfg_valid / cfg_ready  reset_pc, also loaded into the PC
//
// One item per cycle sustained while out_stall does not hold the result register; an item
// passes the input register with the registered regfile read, then execute into the result register.
// The executing item's write to the regfile is forwarded to the item entering behind it.
// rst clears the PC, halt and load tracking, and all registers read as zero.
// in_stall rises only while the result register is full and stalled with an item behind it.
module rv32i_instruction_execute_core #(
  parameter int NUM_REGS = rv32ie_pkg::NUM_REGS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rv32ie_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rv32ie_pkg::out_item_t out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [31:0]           cfg_data
);
  import rv32ie_pkg::*;

  logic        s1_valid;
  in_item_t    s1_item;
  logic        in_beat;
  logic        exec_fire;
  logic [31:0] rs1_val;
  logic [31:0] rs2_val;
  core_state_t st;
  core_state_t st_next;
  rf_write_t   wb;
  rf_write_t   rf_wr;
  out_item_t   res;

  assign cfg_ready = 1'b1;
  assign exec_fire = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !exec_fire;
  assign in_beat   = in_valid && !in_stall;
  assign rf_wr     = '{en: wb.en && exec_fire, idx: wb.idx, data: wb.data};

  rv32ie_regfile #(
    .NUM_REGS(NUM_REGS)
  ) u_regfile (
    .clk    (clk),
    .rst    (rst),
    .ren    (in_beat),
    .raddr1 (in_data.instr_word[19:15]),
    .raddr2 (in_data.instr_word[24:20]),
    .wr     (rf_wr),
    .rdata1 (rs1_val),
    .rdata2 (rs2_val)
  );

  rv32ie_execute u_execute (
    .item    (s1_item),
    .st      (st),
    .rs1_val (rs1_val),
    .rs2_val (rs2_val),
    .st_next (st_next),
    .wb      (wb),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_beat) begin
      s1_valid <= 1'b1;
    end else if (exec_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_data <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (cfg_valid && cfg_ready) begin
      st.pc <= cfg_data;
    end else if (exec_fire) begin
      st <= st_next;
    end
  end

endmodule

@@ tb/sv/rv32i_instruction_execute_core_tb.sv @@
module rv32i_instruction_execute_core_tb;
  import rv32ie_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 64;
  localparam int PHASE_ITEMS = 350;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;

  localparam logic [2:0] F3_BEQ     = 3'd0;
  localparam logic [2:0] F3_BNE     = 3'd1;
  localparam logic [2:0] F3_BR_NONE = 3'd2;
  localparam logic [2:0] F3_BLT     = 3'd4;
  localparam logic [2:0] F3_BGE     = 3'd5;
  localparam logic [2:0] F3_BLTU    = 3'd6;
  localparam logic [2:0] F3_BGEU    = 3'd7;

  localparam logic [2:0] F3_LB      = 3'd0;
  localparam logic [2:0] F3_LH      = 3'd1;
  localparam logic [2:0] F3_LW      = 3'd2;
  localparam logic [2:0] F3_LD_NONE = 3'd3;
  localparam logic [2:0] F3_LBU     = 3'd4;
  localparam logic [2:0] F3_LHU     = 3'd5;

  localparam logic [2:0] F3_SW = 3'd2;

  localparam logic [2:0] F3_JALR = 3'd0;

  localparam logic [6:0] F7_BASE    = 7'h00;
  localparam logic [6:0] F7_ALT     = 7'h20;
  localparam logic [6:0] OPC_UNUSED = 7'h7f;

  class core_scoreboard;
    logic [31:0] regs [NUM_REGS_DEF];
    logic [31:0] pc;
    logic        halt;
    logic        waiting;
    logic [4:0]  ld_rd;
    logic [1:0]  ld_size;
    logic        ld_zext;
    out_item_t   due_results [$];
    int          errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      pc      = '0;
      halt    = 1'b0;
      waiting = 1'b0;
      ld_rd   = '0;
      ld_size = '0;
      ld_zext = 1'b0;
      errors  = 0;
    endfunction

    function void load_boot_pc(logic [31:0] v);
      pc = v;
    endfunction

    function logic [31:0] reg_read(logic [4:0] idx);
      if (idx == 5'd0 || int'(idx) >= NUM_REGS_DEF) return '0;
      return regs[idx];
    endfunction

    function void reg_write(logic [4:0] idx, logic [31:0] v);
      if (idx == 5'd0 || int'(idx) >= NUM_REGS_DEF) return;
      regs[idx] = v;
    endfunction

    function logic [31:0] alu_result(logic [2:0] f3, logic alt, logic [31:0] a, logic [31:0] b);
      case (f3)
        F3_ADD:  return alt ? a - b : a + b;
        F3_SLL:  return a << b[4:0];
        F3_SLT:  return {31'd0, $signed(a) < $signed(b)};
        F3_SLTU: return {31'd0, a < b};
        F3_XOR:  return a ^ b;
        F3_SR:   return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
        F3_OR:   return a | b;
        default: return a & b;
      endcase
    endfunction

    function logic branch_taken(logic [2:0] f3, logic [31:0] a, logic [31:0] b);
      case (f3)
        F3_BEQ:  return a == b;
        F3_BNE:  return a != b;
        F3_BLT:  return $signed(a) < $signed(b);
        F3_BGE:  return !($signed(a) < $signed(b));
        F3_BLTU: return a < b;
        F3_BGEU: return a >= b;
        default: return 1'b0;
      endcase
    endfunction

    function out_item_t execute(in_item_t it);
      out_item_t   r;
      logic [31:0] w, a, b, imm_i, imm_j, imm_b, imm_s, npc, d, ldv;
      logic [2:0]  f3;
      logic [4:0]  rd;
      r     = '0;
      w     = it.instr_word;
      d     = it.load_data;
      f3    = w[14:12];
      rd    = w[11:7];
      a     = reg_read(w[19:15]);
      b     = reg_read(w[24:20]);
      imm_i = {{20{w[31]}}, w[31:20]};
      imm_j = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
      imm_b = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
      imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
      if (it.opcode == ITEM_LOAD_RET) begin
        if (waiting) begin
          case (ld_size)
            SIZE_BYTE: ldv = ld_zext ? {24'd0, d[7:0]} : {{24{d[7]}}, d[7:0]};
            SIZE_HALF: ldv = ld_zext ? {16'd0, d[15:0]} : {{16{d[15]}}, d[15:0]};
            default:   ldv = d;
          endcase
          reg_write(ld_rd, ldv);
          waiting = 1'b0;
        end
      end else if (!waiting) begin
        npc = pc + 32'd4;
        case (w[6:0])
          OPC_LUI:   reg_write(rd, {w[31:12], 12'd0});
          OPC_AUIPC: reg_write(rd, pc + {w[31:12], 12'd0});
          OPC_JAL: begin
            reg_write(rd, pc + 32'd4);
            npc = pc + imm_j;
          end
          OPC_JALR: begin
            npc = (a + imm_i) & ~32'd1;
            reg_write(rd, pc + 32'd4);
          end
          OPC_BRANCH: if (branch_taken(f3, a, b)) npc = pc + imm_b;
          OPC_LOAD: begin
            if (f3 inside {F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU}) begin
              r.mem_request = 1'b1;
              r.mem_addr    = a + imm_i;
              r.mem_size    = f3[1:0];
              waiting       = 1'b1;
              ld_rd         = rd;
              ld_size       = f3[1:0];
              ld_zext       = f3[2];
            end
          end
          OPC_STORE: begin
            if (f3 <= F3_SW) begin
              r.mem_request = 1'b1;
              r.mem_write   = 1'b1;
              r.mem_addr    = a + imm_s;
              r.mem_size    = f3[1:0];
              r.store_data  = b;
            end
          end
          OPC_OP_IMM: reg_write(rd, alu_result(f3, f3 == F3_SR && w[30], a, imm_i));
          OPC_OP:     reg_write(rd, alu_result(f3, w[30], a, b));
          OPC_SYSTEM: halt = 1'b1;
          default: ;
        endcase
        pc = npc;
      end
      r.next_pc      = pc;
      r.halted       = halt;
      r.waiting_load = waiting;
      return r;
    endfunction

    function void note_beat(in_item_t it);
      due_results.insert(due_results.size(), execute(it));
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %h, actual %h", name, want, got);
        errors++;
      end
    endfunction

    function void check_beat(out_item_t got);
      out_item_t want;
      if (due_results.size() == 0) begin
        $error("result beat with nothing outstanding: %h", got);
        errors++;
        return;
      end
      want = due_results.pop_front();
      check_field("next_pc", want.next_pc, got.next_pc);
      check_field("mem_request", 32'(want.mem_request), 32'(got.mem_request));
      check_field("mem_write", 32'(want.mem_write), 32'(got.mem_write));
      check_field("mem_addr", want.mem_addr, got.mem_addr);
      check_field("mem_size", 32'(want.mem_size), 32'(got.mem_size));
      check_field("store_data", want.store_data, got.store_data);
      check_field("halted", 32'(want.halted), 32'(got.halted));
      check_field("waiting_load", 32'(want.waiting_load), 32'(got.waiting_load));
    endfunction
  endclass

  logic        clk;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data  = '0;

  core_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_start    = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int cycle_count   = 0;

  rv32i_instruction_execute_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver pacing; a hold request freezes the output for a long stretch
  always @(posedge clk) begin
    if (hold_start != hold_seen) begin
      hold_seen = hold_start;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_beat(out_data);
  end

  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, OPC_OP};
  endfunction

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] opc);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
  endfunction

  function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
  endfunction

  function automatic logic [31:0] enc_u(logic [19:0] imm, logic [4:0] rd, logic [6:0] opc);
    return {imm, rd, opc};
  endfunction

  function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
  endfunction

  function automatic logic [31:0] random_instr();
    logic [31:0] w;
    int pick;
    w    = $urandom();
    pick = $urandom_range(99);
    if (pick < 10) w[6:0] = OPC_LUI;
    else if (pick < 18) w[6:0] = OPC_AUIPC;
    else if (pick < 24) w[6:0] = OPC_JAL;
    else if (pick < 30) w[6:0] = OPC_JALR;
    else if (pick < 42) w[6:0] = OPC_BRANCH;
    else if (pick < 54) begin
      w[6:0] = OPC_LOAD;
      if ($urandom_range(9) != 0) begin
        case ($urandom_range(4))
          0: w[14:12] = F3_LB;
          1: w[14:12] = F3_LH;
          2: w[14:12] = F3_LW;
          3: w[14:12] = F3_LBU;
          default: w[14:12] = F3_LHU;
        endcase
      end
    end else if (pick < 64) w[6:0] = OPC_STORE;
    else if (pick < 80) begin
      w[6:0] = OPC_OP_IMM;
      if ((w[14:12] == F3_SLL || w[14:12] == F3_SR) && $urandom_range(3) != 0)
        w[31:25] = $urandom_range(1) ? F7_ALT : F7_BASE;
    end else if (pick < 95) begin
      w[6:0] = OPC_OP;
      if ($urandom_range(3) != 0) w[31:25] = $urandom_range(1) ? F7_ALT : F7_BASE;
    end else if (pick < 96) w[6:0] = OPC_SYSTEM;
    return w;
  endfunction

  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sb.note_beat(it);
  endtask

  task automatic exec(input logic [31:0] w);
    send_item(in_item_t'{ITEM_EXEC, w, 32'($urandom())});
  endtask

  task automatic ret(input logic [31:0] d);
    send_item(in_item_t'{ITEM_LOAD_RET, 32'($urandom()), d});
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_boot_pc(input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.load_boot_pc(v);
  endtask

  task automatic run_random(input int count);
    in_item_t it;
    int       done;
    done = 0;
    while (done < count) begin
      it.load_data  = $urandom();
      it.instr_word = random_instr();
      if (sb.waiting) it.opcode = ($urandom_range(19) == 0) ? ITEM_EXEC : ITEM_LOAD_RET;
      else it.opcode = ($urandom_range(29) == 0) ? ITEM_LOAD_RET : ITEM_EXEC;
      if ((it.opcode == ITEM_LOAD_RET) == sb.waiting) done++;
      send_item(it);
    end
  endtask

  task automatic run_directed();
    exec(enc_u(20'hfffff, 5'd1, OPC_LUI));
    exec(enc_i(12'hfff, 5'd0, F3_ADD, 5'd2, OPC_OP_IMM));
    exec(enc_i(12'h7ff, 5'd0, F3_ADD, 5'd3, OPC_OP_IMM));
    exec(enc_u(20'h80000, 5'd4, OPC_AUIPC));
    exec(enc_r(F7_BASE, 5'd3, 5'd1, F3_SLT, 5'd5));
    exec(enc_r(F7_ALT, 5'd2, 5'd3, F3_ADD, 5'd7));
    exec(enc_r(F7_ALT, 5'd3, 5'd1, F3_SR, 5'd8));
    exec(enc_i({F7_ALT, 5'd31}, 5'd1, F3_SR, 5'd9, OPC_OP_IMM));
    // stray funct7 bits, bit 30 clear: logical shift
    exec(enc_r(7'h5f, 5'd3, 5'd1, F3_SR, 5'd10));
    exec(enc_i(12'h005, 5'd2, F3_ADD, 5'd0, OPC_OP_IMM));
    exec(enc_b(13'h0008, 5'd3, 5'd1, F3_BLT));
    exec(enc_b(13'h1000, 5'd3, 5'd1, F3_BGEU));
    exec(enc_b(13'h0ffe, 5'd0, 5'd0, F3_BR_NONE));
    exec(enc_j(21'h100000, 5'd11));
    exec(enc_i(12'hfff, 5'd2, F3_JALR, 5'd12, OPC_JALR));
    exec(enc_s(12'h7ff, 5'd2, 5'd1, F3_SW));
    exec(enc_i(12'h800, 5'd3, F3_LB, 5'd13, OPC_LOAD));
    exec(enc_r(F7_BASE, 5'd2, 5'd2, F3_ADD, 5'd14));
    ret(32'hffff_ff80);
    exec(enc_i(12'h001, 5'd1, F3_LHU, 5'd14, OPC_LOAD));
    ret(32'h1234_8001);
    exec(enc_i(12'h000, 5'd2, F3_LW, 5'd0, OPC_LOAD));
    ret(32'hdead_beef);
    ret(32'h5555_aaaa);
    exec(enc_i(12'h000, 5'd1, F3_LD_NONE, 5'd15, OPC_LOAD));
    exec(enc_i(12'h000, 5'd0, F3_ADD, 5'd0, OPC_SYSTEM));
    exec({25'h1abcdef, OPC_UNUSED});
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    write_boot_pc(32'hffff_fff0);
    send_idle_pct = 30;
    recv_idle_pct = 30;
    run_directed();

    drain();
    write_boot_pc(32'h0000_0000);
    send_idle_pct = 12;
    recv_idle_pct = 87;
    run_random(PHASE_ITEMS);

    drain();
    write_boot_pc(32'hffff_ffff);
    send_idle_pct = 87;
    recv_idle_pct = 12;
    run_random(PHASE_ITEMS);

    drain();
    write_boot_pc($urandom());
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_start++;
    run_random(PHASE_ITEMS);

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
